// ===== rtl/pss_pkg.sv =====
`timescale 1ns / 1ps
package pss_pkg;

    localparam logic [1:0]  OP_TICK    = 2'd0;
    localparam logic [1:0]  OP_PLUCK   = 2'd1;
    localparam logic [1:0]  OP_STOP    = 2'd2;

    localparam logic [14:0] PM_MULT    = 15'd16807;
    localparam logic [30:0] PM_MOD     = 31'h7FFF_FFFF;
    localparam logic [30:0] SEED_RESET = 31'd1;
    localparam logic [15:0] GAIN_RESET = 16'd32768;

    typedef struct packed {
        logic [1:0]  operation;
        logic [10:0] pluck_length;
        logic [15:0] pluck_magnitude;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               active;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK_MUL,
        ST_TICK_WB,
        ST_ZERO,
        ST_PLK_SEED,
        ST_PLK_MUL,
        ST_PLK_WR
    } t_state;

    typedef struct packed {
        logic load_pluck;
        logic seed_step;
        logic noise_mul;
        logic noise_wr;
        logic set_playing;
        logic clr_playing;
        logic tick_mul;
        logic tick_wr;
        logic out_zero;
    } t_cmd;

    typedef struct packed {
        logic fill_last;
        logic playing;
        logic out_full;
    } t_stat;

endpackage

// ===== rtl/pss_ram.sv =====
`timescale 1ns / 1ps
module pss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pss_ctrl.sv =====
`timescale 1ns / 1ps
module pss_ctrl
    import pss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_operation,
    input  t_stat      i_stat,
    output logic       o_in_ready,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_operation)
                        OP_TICK: begin
                            n_state = i_stat.playing ? ST_TICK_MUL : ST_ZERO;
                        end
                        OP_PLUCK: begin
                            o_cmd.load_pluck = 1'b1;
                            n_state          = ST_PLK_SEED;
                        end
                        OP_STOP: begin
                            o_cmd.clr_playing = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_TICK_MUL: begin
                o_cmd.tick_mul = 1'b1;
                n_state        = ST_TICK_WB;
            end
            ST_TICK_WB: begin
                if (!i_stat.out_full) begin
                    o_cmd.tick_wr = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_ZERO: begin
                if (!i_stat.out_full) begin
                    o_cmd.out_zero = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_PLK_SEED: begin
                o_cmd.seed_step = 1'b1;
                n_state         = ST_PLK_MUL;
            end
            ST_PLK_MUL: begin
                o_cmd.noise_mul = 1'b1;
                n_state         = ST_PLK_WR;
            end
            ST_PLK_WR: begin
                o_cmd.noise_wr = 1'b1;
                if (i_stat.fill_last) begin
                    o_cmd.set_playing = 1'b1;
                    n_state           = ST_IDLE;
                end else begin
                    n_state = ST_PLK_SEED;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/pss_dp.sv =====
`timescale 1ns / 1ps
module pss_dp
    import pss_pkg::*;
#(
    parameter int MAX_LINE = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_data,
    input  logic      i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    localparam int AW = $clog2(MAX_LINE);
    localparam int LW = $clog2(MAX_LINE + 1);
    localparam int CW = (LW > 11) ? LW : 11;
    localparam logic [CW-1:0] LEN_MIN = CW'(2);
    localparam logic [CW-1:0] LEN_MAX = CW'(MAX_LINE);

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -18'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    logic [15:0]        r_gain;
    logic [30:0]        r_seed;
    logic               r_playing;
    logic [AW-1:0]      r_index;
    logic [LW-1:0]      r_len;
    logic signed [15:0] r_prev;
    logic [15:0]        r_mag;
    logic [AW-1:0]      r_fill;
    logic signed [32:0] r_noise_prod;
    logic signed [33:0] r_tick_prod;
    logic               r_out_valid;
    t_out_item          r_out_data;

    logic [CW-1:0]      len_in;
    logic [LW-1:0]      n_len;
    logic [45:0]        seed_prod;
    logic [31:0]        seed_sum;
    logic [30:0]        n_seed;
    logic signed [15:0] rdata;
    logic signed [16:0] tick_sum;
    logic signed [15:0] noise_val;
    logic signed [15:0] tick_val;
    logic [LW-1:0]      index_inc;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [15:0]        ram_wdata;

    always_comb begin
        len_in = CW'(i_in_data.pluck_length);
        if (len_in < LEN_MIN) begin
            n_len = LW'(LEN_MIN);
        end else if (len_in > LEN_MAX) begin
            n_len = LW'(LEN_MAX);
        end else begin
            n_len = LW'(len_in);
        end
    end

    assign seed_prod = 46'(r_seed) * 46'(PM_MULT);
    assign seed_sum  = 32'(seed_prod[45:31]) + 32'(seed_prod[30:0]);
    assign n_seed    = (seed_sum >= 32'(PM_MOD)) ? 31'(seed_sum - 32'(PM_MOD))
                                                 : seed_sum[30:0];

    assign tick_sum  = 17'(rdata) + 17'(r_prev);
    assign noise_val = sat16(18'(r_noise_prod >>> 16));
    assign tick_val  = sat16(18'(r_tick_prod >>> 16));
    assign index_inc = LW'(r_index) + LW'(1);

    assign ram_we    = i_cmd.noise_wr | i_cmd.tick_wr;
    assign ram_waddr = i_cmd.tick_wr ? r_index : r_fill;
    assign ram_wdata = i_cmd.tick_wr ? tick_val : noise_val;

    pss_ram #(
        .WIDTH (16),
        .DEPTH (MAX_LINE)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_index),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= GAIN_RESET;
            r_seed      <= SEED_RESET;
            r_playing   <= 1'b0;
            r_index     <= '0;
            r_len       <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_gain <= i_cfg_data;
            end
            if (i_cmd.load_pluck) begin
                r_len <= n_len;
            end
            if (i_cmd.seed_step) begin
                r_seed <= n_seed;
            end
            if (i_cmd.noise_wr) begin
                r_prev <= noise_val;
            end
            if (i_cmd.set_playing) begin
                r_playing <= 1'b1;
                r_index   <= '0;
            end
            if (i_cmd.clr_playing) begin
                r_playing <= 1'b0;
            end
            if (i_cmd.tick_mul) begin
                r_prev <= rdata;
            end
            if (i_cmd.tick_wr) begin
                r_index <= (index_inc >= r_len) ? '0 : r_index + AW'(1);
            end
            if (i_cmd.tick_wr || i_cmd.out_zero) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pluck) begin
            r_mag  <= i_in_data.pluck_magnitude;
            r_fill <= '0;
        end
        if (i_cmd.noise_wr) begin
            r_fill <= r_fill + AW'(1);
        end
        if (i_cmd.noise_mul) begin
            r_noise_prod <= $signed({1'b0, r_mag}) * $signed(r_seed[15:0]);
        end
        if (i_cmd.tick_mul) begin
            r_tick_prod <= tick_sum * $signed({1'b0, r_gain});
        end
        if (i_cmd.tick_wr) begin
            r_out_data.sample <= tick_val;
            r_out_data.active <= 1'b1;
        end else if (i_cmd.out_zero) begin
            r_out_data.sample <= '0;
            r_out_data.active <= 1'b0;
        end
    end

    assign o_stat.fill_last = ((LW'(r_fill) + LW'(1)) == r_len);
    assign o_stat.playing   = r_playing;
    assign o_stat.out_full  = r_out_valid & ~i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out_data;

endmodule

// ===== rtl/plucked_string_synth.sv =====
`timescale 1ns / 1ps
// Tick: the line entry is scaled in the multiply state, then written back and registered to the
// output in the write-back state, which waits while the output is full. Stop and unused codes
// leave the block idle. Pluck of length L: seed step, noise multiply and line write per entry
// (single write port). Output register lets a new item be accepted while a result waits.
// Reset (synchronous, active low) resets control, seed, index, length and gain;
// the delay line is not cleared and is read only after a pluck fills it.
module plucked_string_synth
    import pss_pkg::*;
#(
    parameter int MAX_LINE = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    pss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_in_data.operation),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    pss_dp #(
        .MAX_LINE (MAX_LINE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/pss_checker.sv =====
`timescale 1ns / 1ps
module pss_checker
    import pss_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input t_in_item    i_in_data,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out_item   o_out_data,
    input logic        o_cfg_ready
);

    logic in_xfer;
    assign in_xfer = i_in_valid & o_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output changed while stalled");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.active |-> o_out_data.sample == 16'sd0)
        else $error("silent result with nonzero sample");

    a_pluck_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in_data.operation == OP_PLUCK |=> !o_in_ready ##1 !o_in_ready)
        else $error("pluck did not hold off input");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in_data.operation == OP_TICK |=> !o_in_ready)
        else $error("tick did not hold off input");

    a_stop_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in_data.operation == OP_STOP |=> o_in_ready && o_cfg_ready)
        else $error("stop did not return to idle");

endmodule

bind plucked_string_synth pss_checker u_pss_checker (.*);
